// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque assertion failed");
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque assertion failed");
`else
`define DEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/deq_pkg.sv =====
// Types and constants of the double-ended queue.
package deq_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned CFG_W = 9;
  localparam int unsigned OCC_W = 9;
  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 9'd256;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_QUERY      = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

endpackage

// ===== hw/rtl/deq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// Bounded double-ended queue of signed 32-bit values held in a ring buffer RAM.
// Pushes, queries, refused commands and a pop that empties the queue answer
// from idle; other pops pass through the read state, as the new front or back
// element comes from the element RAM's registered read data. Front and back
// elements are kept in registers, so every other command needs no RAM read.
// The user must write the capacity register through the cfg_ port only while
// the queue is idle (not enforced); values above DEPTH saturate at DEPTH.
`include "assert_macros.svh"

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic                    clk,
  input  logic                    rst_n,

  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        cfg_max_entries,

  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              in_command,
  input  logic signed [VAL_W-1:0] in_value,

  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic signed [VAL_W-1:0] out_popped_value,
  output logic [OCC_W-1:0]        out_occupancy,
  output logic signed [VAL_W-1:0] out_front_value,
  output logic signed [VAL_W-1:0] out_back_value
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  state_t            state_r, state_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [VAL_W-1:0]  front_r, front_nxt;
  logic [VAL_W-1:0]  back_r, back_nxt;
  logic [CFG_W-1:0]  max_entries_r;
  logic              pend_front_r, pend_front_nxt;

  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [VAL_W-1:0]  popped_r, popped_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [VAL_W-1:0]  ofront_r, ofront_nxt;
  logic [VAL_W-1:0]  oback_r, oback_nxt;

  logic              accept;
  logic              need_read;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;
  logic [WW-1:0]     cap;
  logic              full;
  logic              empty;
  logic [AW-1:0]     head_prev, head_next, tail_prev, tail_prev2;
  status_t           st;
  logic [VAL_W-1:0]  popped;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    return (i == '0) ? LAST_IDX : i - AW'(1);
  endfunction

  deq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .re    (need_read),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;

  assign cap   = (WW'(max_entries_r) > WW'(DEPTH)) ? WW'(DEPTH) : WW'(max_entries_r);
  assign full  = WW'(count_r) >= cap;
  assign empty = (count_r == '0);

  assign head_prev  = ring_prev(head_r);
  assign head_next  = ring_next(head_r);
  assign tail_prev  = ring_prev(tail_r);
  assign tail_prev2 = ring_prev(tail_prev);

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    pend_front_nxt = pend_front_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    status_nxt     = status_r;
    popped_nxt     = popped_r;
    occ_nxt        = occ_r;
    ofront_nxt     = ofront_r;
    oback_nxt      = oback_r;
    ram_we         = 1'b0;
    ram_waddr      = head_prev;
    ram_raddr      = head_next;
    need_read      = 1'b0;
    st             = ST_OK;
    popped         = '0;

    if (accept) begin
      case (cmd_t'(in_command))
        CMD_PUSH_FRONT: begin
          if (full) begin
            st = ST_FULL;
          end else begin
            head_nxt  = head_prev;
            ram_we    = 1'b1;
            ram_waddr = head_prev;
            count_nxt = count_r + CW'(1);
            front_nxt = in_value;
            if (empty) begin
              back_nxt = in_value;
            end
          end
        end
        CMD_PUSH_BACK: begin
          if (full) begin
            st = ST_FULL;
          end else begin
            tail_nxt  = ring_next(tail_r);
            ram_we    = 1'b1;
            ram_waddr = tail_r;
            count_nxt = count_r + CW'(1);
            back_nxt  = in_value;
            if (empty) begin
              front_nxt = in_value;
            end
          end
        end
        CMD_POP_FRONT: begin
          if (empty) begin
            st = ST_EMPTY;
          end else begin
            popped         = front_r;
            head_nxt       = head_next;
            count_nxt      = count_r - CW'(1);
            need_read      = (count_r != CW'(1));
            ram_raddr      = head_next;
            pend_front_nxt = 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (empty) begin
            st = ST_EMPTY;
          end else begin
            popped         = back_r;
            tail_nxt       = tail_prev;
            count_nxt      = count_r - CW'(1);
            need_read      = (count_r != CW'(1));
            ram_raddr      = tail_prev2;
            pend_front_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase

      status_nxt = st;
      popped_nxt = popped;
      occ_nxt    = OCC_W'(count_nxt);
      ofront_nxt = (count_nxt != '0) ? front_nxt : '0;
      oback_nxt  = (count_nxt != '0) ? back_nxt : '0;
      if (need_read) begin
        state_nxt = S_READ;
      end else begin
        out_valid_nxt = 1'b1;
      end
    end

    if (state_r == S_READ) begin
      state_nxt     = S_IDLE;
      out_valid_nxt = 1'b1;
      if (pend_front_r) begin
        front_nxt  = ram_rdata;
        ofront_nxt = ram_rdata;
      end else begin
        back_nxt  = ram_rdata;
        oback_nxt = ram_rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      head_r        <= '0;
      tail_r        <= '0;
      count_r       <= '0;
      max_entries_r <= MAX_ENTRIES_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        max_entries_r <= cfg_max_entries;
      end
    end
  end

  always_ff @(posedge clk) begin
    front_r      <= front_nxt;
    back_r       <= back_nxt;
    pend_front_r <= pend_front_nxt;
    status_r     <= status_nxt;
    popped_r     <= popped_nxt;
    occ_r        <= occ_nxt;
    ofront_r     <= ofront_nxt;
    oback_r      <= oback_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_popped_value = popped_r;
  assign out_occupancy    = occ_r;
  assign out_front_value  = ofront_r;
  assign out_back_value   = oback_r;

  `DEQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `DEQ_ASSERT_IMP(a_empty_ptrs, clk, rst_n, count_r == '0, head_r == tail_r)
  `DEQ_ASSERT_IMP(a_read_blocks_in, clk, rst_n, state_r == S_READ, !in_ready && !out_valid_r)
  `DEQ_ASSERT_NEXT(a_read_delivers, clk, rst_n, state_r == S_READ, out_valid_r && state_r == S_IDLE)

endmodule
